[rtl/prl_pkg.sv]
// shared types, character codes and constants of the port range list parser
`timescale 1ns / 1ps

package prl_pkg;

    localparam int PORT_MAX_DEF = 65535;
    localparam int QUEUE_DEPTH  = 2;
    localparam int ACC_W        = 17;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;
    localparam logic [7:0] CHAR_COMMA = 8'd44;
    localparam logic [7:0] CHAR_DASH  = 8'd45;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_CR    = 8'd13;

    localparam logic [1:0] ST_RANGE  = 2'd0;
    localparam logic [1:0] ST_ENDED  = 2'd1;
    localparam logic [1:0] ST_SYNTAX = 2'd2;
    localparam logic [1:0] ST_VALUE  = 2'd3;

    typedef enum logic [2:0] {
        CL_DIGIT = 3'd0,
        CL_SPACE = 3'd1,
        CL_COMMA = 3'd2,
        CL_DASH  = 3'd3,
        CL_OTHER = 3'd4,
        CL_END   = 3'd5
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
    } token_t;

    typedef enum logic [7:0] {
        PH_START       = 8'b0000_0001,
        PH_FIRST_NUM   = 8'b0000_0010,
        PH_AFTER_LOW   = 8'b0000_0100,
        PH_AFTER_DASH  = 8'b0000_1000,
        PH_SECOND_NUM  = 8'b0001_0000,
        PH_AFTER_COMMA = 8'b0010_0000,
        PH_AFTER_HIGH  = 8'b0100_0000,
        PH_ERROR       = 8'b1000_0000
    } phase_t;

endpackage

[rtl/prl_if.sv]
// valid/ready channel interfaces for characters in and ranges out
`timescale 1ns / 1ps

interface prl_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

interface prl_range_if;
    logic        valid;
    logic        ready;
    logic [15:0] port_low;
    logic [15:0] port_high;
    logic [1:0]  status;
    logic        done_res;

    modport source (output valid, output port_low, output port_high, output status,
                    output done_res, input ready);
    modport sink   (input valid, input port_low, input port_high, input status,
                    input done_res, output ready);
endinterface

[rtl/prl_front.sv]
// front end: accepts character words and classifies them into tokens
`timescale 1ns / 1ps

module prl_front (
    prl_char_if.sink      chars,
    input  logic          q_full,
    output logic          push,
    output prl_pkg::token_t push_token
);
    import prl_pkg::*;

    logic is_dig;
    logic is_sp;

    assign is_dig = (chars.char_code >= CHAR_ZERO) && (chars.char_code <= CHAR_NINE);
    assign is_sp  = (chars.char_code == CHAR_SPACE) ||
                    ((chars.char_code >= CHAR_TAB) && (chars.char_code <= CHAR_CR));

    assign chars.ready = !q_full;
    assign push        = chars.valid && !q_full;

    always_comb
    begin
        push_token.digit = chars.char_code[3:0] - CHAR_ZERO[3:0];
        if (chars.end_marker)
            push_token.cls = CL_END;
        else if (is_dig)
            push_token.cls = CL_DIGIT;
        else if (is_sp)
            push_token.cls = CL_SPACE;
        else if (chars.char_code == CHAR_COMMA)
            push_token.cls = CL_COMMA;
        else if (chars.char_code == CHAR_DASH)
            push_token.cls = CL_DASH;
        else
            push_token.cls = CL_OTHER;
    end

endmodule

[rtl/prl_queue.sv]
// short token queue between front end and parser back end
`timescale 1ns / 1ps

module prl_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  prl_pkg::token_t push_token,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output prl_pkg::token_t head
);
    import prl_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_token;
    end

endmodule

[rtl/prl_back.sv]
// back end: range parser state machine with registered result word
`timescale 1ns / 1ps

module prl_back #(
    parameter int PORT_MAX = prl_pkg::PORT_MAX_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_not_empty,
    input  prl_pkg::token_t head,
    output logic            pop,
    prl_range_if.source     ranges
);
    import prl_pkg::*;

    localparam logic [ACC_W-1:0] PMAX    = ACC_W'(PORT_MAX);
    localparam logic [ACC_W-1:0] PMAX_P1 = ACC_W'(PORT_MAX + 1);
    localparam logic [ACC_W+2:0] PMAX_W  = (ACC_W+3)'(PORT_MAX);

    phase_t            phase_reg, phase_next;
    logic [ACC_W-1:0]  first_reg, first_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic              out_valid_reg, out_valid_next;
    logic [15:0]       lo_reg, hi_reg;
    logic [1:0]        st_reg;
    logic              done_reg;

    logic              emit;
    logic [15:0]       emit_lo, emit_hi;
    logic [1:0]        emit_st;
    logic              emit_done;
    logic [ACC_W+2:0]  acc_x10;

    assign pop     = q_not_empty && (!out_valid_reg || ranges.ready);
    assign acc_x10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + (ACC_W+3)'(head.digit);

    always_comb
    begin
        phase_t           ph;
        logic [ACC_W-1:0] fv;
        logic             is_end;
        logic             handled;

        ph         = phase_reg;
        fv         = first_reg;
        is_end     = (head.cls == CL_END);
        handled    = 1'b0;
        phase_next = phase_reg;
        first_next = first_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        emit_lo    = '0;
        emit_hi    = '0;
        emit_st    = ST_RANGE;
        emit_done  = 1'b0;

        if (phase_reg == PH_ERROR)
        begin
            handled = 1'b1;
            if (is_end)
            begin
                phase_next = PH_START;
                first_next = '0;
                acc_next   = '0;
            end
        end
        else if (phase_reg == PH_FIRST_NUM || phase_reg == PH_SECOND_NUM)
        begin
            if (head.cls == CL_DIGIT)
            begin
                handled  = 1'b1;
                acc_next = (acc_x10 > PMAX_W) ? PMAX_P1 : acc_x10[ACC_W-1:0];
            end
            else if (acc_reg > PMAX ||
                     (phase_reg == PH_SECOND_NUM && acc_reg < first_reg))
            begin
                // value error, checked before the ending character is looked at
                handled = 1'b1;
                emit    = 1'b1;
                emit_st = ST_VALUE;
            end
            else if (phase_reg == PH_FIRST_NUM)
            begin
                fv         = acc_reg;
                first_next = acc_reg;
                ph         = PH_AFTER_LOW;
                phase_next = PH_AFTER_LOW;
            end
            else
            begin
                ph         = PH_AFTER_HIGH;
                phase_next = PH_AFTER_HIGH;
            end
        end

        if (!handled)
        begin
            case (ph)
                PH_START, PH_AFTER_COMMA:
                begin
                    if (is_end)
                    begin
                        emit    = 1'b1;
                        emit_st = (ph == PH_AFTER_COMMA) ? ST_ENDED : ST_SYNTAX;
                    end
                    else if (head.cls == CL_SPACE)
                        phase_next = PH_START;
                    else if (head.cls == CL_DIGIT)
                    begin
                        acc_next   = ACC_W'(head.digit);
                        phase_next = PH_FIRST_NUM;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        emit_st = ST_SYNTAX;
                    end
                end
                PH_AFTER_LOW:
                begin
                    if (is_end || head.cls == CL_COMMA)
                    begin
                        emit       = 1'b1;
                        emit_lo    = fv[15:0];
                        emit_hi    = fv[15:0];
                        phase_next = PH_AFTER_COMMA;
                    end
                    else if (head.cls == CL_DASH)
                        phase_next = PH_AFTER_DASH;
                    else if (head.cls != CL_SPACE)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_SYNTAX;
                    end
                end
                PH_AFTER_DASH:
                begin
                    if (head.cls == CL_DIGIT)
                    begin
                        acc_next   = ACC_W'(head.digit);
                        phase_next = PH_SECOND_NUM;
                    end
                    else
                    begin
                        emit    = 1'b1;
                        emit_st = ST_SYNTAX;
                    end
                end
                PH_AFTER_HIGH:
                begin
                    if (is_end || head.cls == CL_COMMA)
                    begin
                        emit       = 1'b1;
                        emit_lo    = fv[15:0];
                        emit_hi    = acc_reg[15:0];
                        phase_next = PH_AFTER_COMMA;
                    end
                    else if (head.cls != CL_SPACE)
                    begin
                        emit    = 1'b1;
                        emit_st = ST_SYNTAX;
                    end
                end
                default:
                begin
                    emit    = 1'b1;
                    emit_st = ST_SYNTAX;
                end
            endcase
        end

        // errors park the parser until the end word; the end word always clears
        if (emit && emit_st != ST_RANGE && !is_end)
            phase_next = PH_ERROR;
        if (is_end)
        begin
            emit_done  = emit;
            phase_next = PH_START;
            first_next = '0;
            acc_next   = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = emit;
        else if (ranges.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            first_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                first_reg <= first_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            lo_reg   <= emit_lo;
            hi_reg   <= emit_hi;
            st_reg   <= emit_st;
            done_reg <= emit_done;
        end
    end

    assign ranges.valid     = out_valid_reg;
    assign ranges.port_low  = lo_reg;
    assign ranges.port_high = hi_reg;
    assign ranges.status    = st_reg;
    assign ranges.done_res  = done_reg;

endmodule

[rtl/port_range_list_parser.sv]
// top level of the port range list parser
`timescale 1ns / 1ps

// Parses text such as "21-25,53,80" one character word per cycle, closed by an
// end-of-string word, and returns one word per finished range (low and high
// port) or one status word for a trailing comma, a syntax error or a bad port
// value. Throughput is one character word per clock while the token queue is
// not full: the front end classifies each word into a two-entry token queue,
// the back end state machine consumes one token per cycle while the result
// register is not held and loads that register. The input stalls only when the
// token queue is full, which happens when the result register is held by the
// downstream side. After an error, characters are dropped until the end word.

module port_range_list_parser #(
    parameter int PORT_MAX = prl_pkg::PORT_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    prl_char_if.sink     chars,
    prl_range_if.source  ranges
);
    import prl_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_not_empty;
    token_t push_token;
    token_t head;

    prl_front u_front (
        .chars      (chars),
        .q_full     (q_full),
        .push       (push),
        .push_token (push_token)
    );

    prl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (head)
    );

    prl_back #(
        .PORT_MAX (PORT_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .head        (head),
        .pop         (pop),
        .ranges      (ranges)
    );

endmodule
